[hw/rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and UTF-8 helpers of the JSON string
// unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ESC    = 3'd1,
    PH_HEX    = 3'd2,
    PH_LA_BS  = 3'd3,
    PH_LA_U   = 3'd4,
    PH_LA_HEX = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_PROC,
    CS_EMIT,
    CS_NEXT
  } ctrl_state_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;

  localparam logic [15:0] CP_REPL   = 16'hFFFD;
  localparam logic [15:0] HI_FIRST  = 16'hD800;
  localparam logic [15:0] HI_LAST   = 16'hDBFF;
  localparam logic [15:0] LO_FIRST  = 16'hDC00;
  localparam logic [15:0] LO_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam int HELD_DEPTH = 6;

  typedef struct packed {
    logic load_in;
    logic proc;
    logic emit;
    logic load_replay;
    logic flush;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_more;
    logic emit_last;
    logic replay_more;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [2:0]      count;
    logic [3:0][7:0] bytes;
  } utf8_t;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic utf8_t single_byte(input logic [7:0] b);
    utf8_t r;
    r = '0;
    r.count = 3'd1;
    r.bytes[0] = b;
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= 21'h7F) begin
      r.count = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      r.count = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      r.count = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.count = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

[hw/rtl/jsu_ctrl.sv]
// ----------------------------------------------------------------------------
// jsu_ctrl
// Sequencer of the unescaper: accept a request, decode one byte, emit its
// bytes, then decode held bytes again or close the request.
// ----------------------------------------------------------------------------
module jsu_ctrl
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = CS_PROC;
        end
      end
      CS_PROC: begin
        cmd.proc   = 1'b1;
        state_next = CS_EMIT;
      end
      CS_EMIT: begin
        if (!status.emit_more) begin
          state_next = CS_NEXT;
        end else if (!status.pend_valid || status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            state_next = CS_NEXT;
          end
        end
      end
      CS_NEXT: begin
        if (status.replay_more) begin
          cmd.load_replay = 1'b1;
          state_next      = CS_PROC;
        end else if (!status.pend_valid) begin
          cmd.finish = 1'b1;
          state_next = CS_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          cmd.finish = 1'b1;
          state_next = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/jsu_datapath.sv]
// ----------------------------------------------------------------------------
// jsu_datapath
// Escape decoder state, held look-ahead bytes, replay list, UTF-8 byte
// buffer and the output register with one byte of look-behind.
// ----------------------------------------------------------------------------
module jsu_datapath
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  logic [7:0] in_byte,
  input  logic       is_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       string_done
);

  // decoder state
  phase_t      phase;
  logic [15:0] code_acc;
  logic [2:0]  digit_count;
  logic        bad_digit;
  logic [15:0] high_unit;
  logic [7:0]  held [HELD_DEPTH];

  // byte under decode
  logic [7:0]  cur;
  logic        cur_fin;
  logic        step_fin;

  // replay list
  logic [7:0]  rp [HELD_DEPTH];
  logic [2:0]  rn;
  logic [2:0]  rk;
  logic        rp_fin;

  // bytes of one decode
  logic [3:0][7:0] ebuf;
  logic [2:0]      ecount;
  logic [2:0]      eidx;

  logic [7:0]  pend;
  logic        pend_valid;

  // decode step
  phase_t      phase_next;
  logic [15:0] code_acc_next;
  logic [2:0]  digit_count_next;
  logic        bad_digit_next;
  logic [15:0] high_unit_next;
  logic [7:0]  held_next [HELD_DEPTH];
  logic [7:0]  rp_next [HELD_DEPTH];
  utf8_t       enc;
  logic        new_rep;
  logic [2:0]  rep_len;
  logic        rep_cur;
  logic [2:0]  rep_cur_idx;
  logic [4:0]  dig;
  logic [15:0] acc_dig;
  logic        bad_dig;
  logic [2:0]  dc_inc;
  logic [15:0] cp_hex;
  logic [20:0] cp_supp;
  logic        out_free;
  logic        push;

  assign dig     = hex_digit(cur);
  assign acc_dig = {code_acc[11:0], dig[3:0]};
  assign bad_dig = bad_digit | ~dig[4];
  assign dc_inc  = digit_count + 3'd1;
  assign cp_hex  = bad_dig ? CP_REPL : acc_dig;
  assign cp_supp = SUPP_BASE + {1'b0, high_unit[9:0], acc_dig[9:0]};

  always_comb begin
    phase_next       = phase;
    code_acc_next    = code_acc;
    digit_count_next = digit_count;
    bad_digit_next   = bad_digit;
    high_unit_next   = high_unit;
    for (int k = 0; k < HELD_DEPTH; k++) begin
      held_next[k] = held[k];
    end
    enc         = '0;
    new_rep     = 1'b0;
    rep_len     = 3'd0;
    rep_cur     = 1'b0;
    rep_cur_idx = 3'd0;
    unique case (phase)
      PH_IDLE: begin
        if (cur == CH_BSLASH && !cur_fin) begin
          phase_next = PH_ESC;
        end else begin
          enc = single_byte(cur);
        end
      end
      PH_ESC: begin
        phase_next = PH_IDLE;
        case (cur)
          CH_N: enc = single_byte(CH_LF);
          CH_R: enc = single_byte(CH_CR);
          CH_T: enc = single_byte(CH_TAB);
          CH_B: enc = single_byte(CH_BS);
          CH_F: enc = single_byte(CH_FF);
          CH_U: begin
            if (cur_fin) begin
              enc = single_byte(CH_QMARK);
            end else begin
              phase_next       = PH_HEX;
              code_acc_next    = 16'd0;
              digit_count_next = 3'd0;
              bad_digit_next   = 1'b0;
            end
          end
          default: enc = single_byte(cur);
        endcase
      end
      PH_HEX: begin
        held_next[{1'b0, digit_count[1:0]}] = cur;
        if (dc_inc >= 3'd4) begin
          phase_next       = PH_IDLE;
          code_acc_next    = 16'd0;
          digit_count_next = 3'd0;
          bad_digit_next   = 1'b0;
          if (cp_hex >= HI_FIRST && cp_hex <= HI_LAST && !cur_fin) begin
            high_unit_next = cp_hex;
            phase_next     = PH_LA_BS;
          end else begin
            enc = utf8_encode({5'd0, cp_hex});
          end
        end else if (cur_fin) begin
          enc              = single_byte(CH_QMARK);
          new_rep          = 1'b1;
          rep_len          = dc_inc;
          phase_next       = PH_IDLE;
          code_acc_next    = 16'd0;
          digit_count_next = 3'd0;
          bad_digit_next   = 1'b0;
        end else begin
          code_acc_next    = acc_dig;
          digit_count_next = dc_inc;
          bad_digit_next   = bad_dig;
        end
      end
      PH_LA_BS: begin
        if (cur == CH_BSLASH && !cur_fin) begin
          held_next[0] = cur;
          phase_next   = PH_LA_U;
        end else begin
          enc         = utf8_encode({5'd0, high_unit});
          new_rep     = 1'b1;
          rep_len     = 3'd1;
          rep_cur     = 1'b1;
          rep_cur_idx = 3'd0;
          phase_next  = PH_IDLE;
        end
      end
      PH_LA_U: begin
        if (cur == CH_U && !cur_fin) begin
          held_next[1]     = cur;
          phase_next       = PH_LA_HEX;
          code_acc_next    = 16'd0;
          digit_count_next = 3'd0;
          bad_digit_next   = 1'b0;
        end else begin
          enc         = utf8_encode({5'd0, high_unit});
          new_rep     = 1'b1;
          rep_len     = 3'd2;
          rep_cur     = 1'b1;
          rep_cur_idx = 3'd1;
          phase_next  = PH_IDLE;
        end
      end
      PH_LA_HEX: begin
        held_next[3'd2 + {1'b0, digit_count[1:0]}] = cur;
        if (dc_inc >= 3'd4) begin
          if (!bad_dig && acc_dig >= LO_FIRST && acc_dig <= LO_LAST) begin
            enc = utf8_encode(cp_supp);
          end else begin
            enc     = utf8_encode({5'd0, high_unit});
            new_rep = 1'b1;
            rep_len = 3'd6;
          end
          phase_next       = PH_IDLE;
          code_acc_next    = 16'd0;
          digit_count_next = 3'd0;
          bad_digit_next   = 1'b0;
        end else if (cur_fin) begin
          enc              = utf8_encode({5'd0, high_unit});
          new_rep          = 1'b1;
          rep_len          = 3'd2 + dc_inc;
          phase_next       = PH_IDLE;
          code_acc_next    = 16'd0;
          digit_count_next = 3'd0;
          bad_digit_next   = 1'b0;
        end else begin
          code_acc_next    = acc_dig;
          digit_count_next = dc_inc;
          bad_digit_next   = bad_dig;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        enc        = single_byte(cur);
      end
    endcase
    for (int k = 0; k < HELD_DEPTH; k++) begin
      rp_next[k] = held_next[k];
    end
    if (rep_cur) begin
      rp_next[rep_cur_idx] = cur;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign push     = (cmd.emit && pend_valid) || cmd.flush;

  assign status.emit_more   = eidx < ecount;
  assign status.emit_last   = 3'(eidx + 3'd1) == ecount;
  assign status.replay_more = rk < rn;
  assign status.pend_valid  = pend_valid;
  assign status.out_free    = out_free;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      code_acc    <= 16'd0;
      digit_count <= 3'd0;
      bad_digit   <= 1'b0;
      high_unit   <= 16'd0;
      rn          <= 3'd0;
      rk          <= 3'd0;
      ecount      <= 3'd0;
      eidx        <= 3'd0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        rn <= 3'd0;
        rk <= 3'd0;
      end
      if (cmd.load_replay) begin
        rk <= rk + 3'd1;
      end
      if (cmd.proc) begin
        phase       <= phase_next;
        code_acc    <= code_acc_next;
        digit_count <= digit_count_next;
        bad_digit   <= bad_digit_next;
        high_unit   <= high_unit_next;
        ecount      <= enc.count;
        eidx        <= 3'd0;
        if (new_rep) begin
          rn <= rep_len;
          rk <= 3'd0;
        end
      end
      if (cmd.emit) begin
        eidx       <= eidx + 3'd1;
        pend_valid <= 1'b1;
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if (cmd.finish && step_fin) begin
        phase       <= PH_IDLE;
        code_acc    <= 16'd0;
        digit_count <= 3'd0;
        bad_digit   <= 1'b0;
        high_unit   <= 16'd0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur      <= in_byte;
      cur_fin  <= is_final;
      step_fin <= is_final;
    end
    if (cmd.load_replay) begin
      cur     <= rp[rk];
      cur_fin <= rp_fin && (3'(rk + 3'd1) == rn);
    end
    if (cmd.proc) begin
      for (int k = 0; k < HELD_DEPTH; k++) begin
        held[k] <= held_next[k];
      end
      ebuf <= enc.bytes;
      if (new_rep) begin
        for (int k = 0; k < HELD_DEPTH; k++) begin
          rp[k] <= rp_next[k];
        end
        rp_fin <= cur_fin;
      end
    end
    if (cmd.emit) begin
      pend <= ebuf[eidx[1:0]];
    end
    if (push) begin
      out_byte    <= pend;
      run_end     <= cmd.flush;
      string_done <= cmd.flush && step_fin;
    end
  end

  a_replay_index: assert property (@(posedge clk) disable iff (rst) rk <= rn)
    else $error("replay index past end of list");

  a_emit_index: assert property (@(posedge clk) disable iff (rst) eidx <= ecount)
    else $error("emit index past byte count");

  a_emit_has_byte: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.emit_more)
    else $error("emit without a buffered byte");

  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |-> !pend_valid && !status.emit_more)
    else $error("new request while bytes of the last one remain");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && step_fin |=> phase == PH_IDLE && digit_count == 3'd0
      && high_unit == 16'd0)
    else $error("decoder not idle after final byte");

endmodule

[hw/rtl/json_string_unescape_utf8_top.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// JSON string body unescaper with UTF-8 output for \u escapes.
// ----------------------------------------------------------------------------
// Takes one byte of a JSON string body per request, is_final on the last one,
// and returns the decoded bytes; run_end marks the last byte caused by a
// request and string_done the last byte of the string. One request is worked
// on at a time. The sequencer decodes one byte per pass, and decodes again
// each held byte after a broken surrogate pair or a short \u at string end;
// it moves decoded bytes one a cycle, stalling while the output register is
// full, through a single look-behind register into the output register; the
// next request is taken while the last byte still waits in that register.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       is_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       string_done
);

  dp_cmd_t    cmd;
  dp_status_t status;

  jsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  jsu_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_byte     (in_byte),
    .is_final    (is_final),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_end     (run_end),
    .string_done (string_done)
  );

endmodule

[sim/json_string_unescape_utf8_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_check
// Request and output checker for the JSON string unescaper.
// ----------------------------------------------------------------------------
// Watches both handshakes. Each accepted request is run through a behavioral
// unescaper kept beside the block, and the bytes it gives are queued with
// their run_end and string_done marks. Each accepted output byte is compared
// field by field with the oldest queued byte. Failures and the number of
// bytes still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_check
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       is_final,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       run_end,
  input  logic       string_done,
  output int         errors,
  output int         pending
);

  localparam int MAX_STEP_BYTES = 8;

  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } replay_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } out_rec_t;

  phase_t      ph;
  logic [15:0] acc;
  logic [2:0]  ndig;
  logic        bad;
  logic [15:0] hi_unit;
  logic [7:0]  held [HELD_DEPTH];
  logic [7:0]  step_bytes [$];
  out_rec_t    expected_bytes [$];
  int          err_n = 0;

  function automatic void put_byte(input logic [7:0] b);
    if (step_bytes.size() < MAX_STEP_BYTES) begin
      step_bytes.push_back(b);
    end
  endfunction

  function automatic void put_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      put_byte(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      put_byte({3'b110, cp[10:6]});
      put_byte({2'b10, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      put_byte({4'b1110, cp[15:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end else begin
      put_byte({5'b11110, cp[20:18]});
      put_byte({2'b10, cp[17:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void start_digits(input phase_t p);
    ph = p;
    acc = '0;
    ndig = '0;
    bad = 1'b0;
  endfunction

  function automatic void take_digit(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= CH_DIG0 && b <= CH_DIG9) begin
      v = 4'(b - CH_DIG0);
    end else if (b >= CH_LOW_A && b <= CH_LOW_F) begin
      v = 4'(b - CH_LOW_A + 8'd10);
    end else if (b >= CH_UP_A && b <= CH_UP_F) begin
      v = 4'(b - CH_UP_A + 8'd10);
    end else begin
      bad = 1'b1;
    end
    acc = {acc[11:0], v};
    ndig = ndig + 3'd1;
  endfunction

  function automatic void decode_request(input logic [7:0] b, input logic f);
    replay_t     work [$];
    replay_t     cur;
    replay_t     nxt;
    logic [7:0]  rp [HELD_DEPTH];
    logic [15:0] unit;
    out_rec_t    rec;
    int          rn;
    int          k;
    step_bytes.delete();
    cur.data = b;
    cur.fin = f;
    work.push_back(cur);
    // held bytes go back to the front so they are decoded depth first
    while (work.size() > 0) begin
      cur = work.pop_front();
      rn = 0;
      case (ph)
        PH_IDLE: begin
          if (cur.data == CH_BSLASH && !cur.fin) begin
            ph = PH_ESC;
          end else begin
            put_byte(cur.data);
          end
        end
        PH_ESC: begin
          ph = PH_IDLE;
          case (cur.data)
            CH_N: put_byte(CH_LF);
            CH_R: put_byte(CH_CR);
            CH_T: put_byte(CH_TAB);
            CH_B: put_byte(CH_BS);
            CH_F: put_byte(CH_FF);
            CH_U: begin
              if (cur.fin) begin
                put_byte(CH_QMARK);
              end else begin
                start_digits(PH_HEX);
              end
            end
            default: put_byte(cur.data);
          endcase
        end
        PH_HEX: begin
          held[{1'b0, ndig[1:0]}] = cur.data;
          take_digit(cur.data);
          if (ndig >= 3'd4) begin
            unit = bad ? CP_REPL : acc;
            start_digits(PH_IDLE);
            if (unit >= HI_FIRST && unit <= HI_LAST && !cur.fin) begin
              hi_unit = unit;
              ph = PH_LA_BS;
            end else begin
              put_code_point({5'd0, unit});
            end
          end else if (cur.fin) begin
            put_byte(CH_QMARK);
            rn = ndig;
            for (k = 0; k < rn; k++) rp[k] = held[k];
            start_digits(PH_IDLE);
          end
        end
        PH_LA_BS: begin
          if (cur.data == CH_BSLASH && !cur.fin) begin
            held[0] = cur.data;
            ph = PH_LA_U;
          end else begin
            put_code_point({5'd0, hi_unit});
            rp[0] = cur.data;
            rn = 1;
            ph = PH_IDLE;
          end
        end
        PH_LA_U: begin
          if (cur.data == CH_U && !cur.fin) begin
            held[1] = cur.data;
            start_digits(PH_LA_HEX);
          end else begin
            put_code_point({5'd0, hi_unit});
            rp[0] = held[0];
            rp[1] = cur.data;
            rn = 2;
            ph = PH_IDLE;
          end
        end
        PH_LA_HEX: begin
          held[3'd2 + {1'b0, ndig[1:0]}] = cur.data;
          take_digit(cur.data);
          if (ndig >= 3'd4) begin
            if (!bad && acc >= LO_FIRST && acc <= LO_LAST) begin
              put_code_point(SUPP_BASE + {1'b0, hi_unit[9:0], acc[9:0]});
            end else begin
              put_code_point({5'd0, hi_unit});
              rn = HELD_DEPTH;
              for (k = 0; k < rn; k++) rp[k] = held[k];
            end
            start_digits(PH_IDLE);
          end else if (cur.fin) begin
            put_code_point({5'd0, hi_unit});
            rn = 2 + ndig;
            for (k = 0; k < rn; k++) rp[k] = held[k];
            start_digits(PH_IDLE);
          end
        end
        default: begin
          ph = PH_IDLE;
          put_byte(cur.data);
        end
      endcase
      for (k = rn - 1; k >= 0; k--) begin
        nxt.data = rp[k];
        nxt.fin = cur.fin && (k == rn - 1);
        work.push_front(nxt);
      end
    end
    if (f) begin
      start_digits(PH_IDLE);
      hi_unit = '0;
    end
    for (k = 0; k < step_bytes.size(); k++) begin
      rec.data = step_bytes[k];
      rec.last = (k == step_bytes.size() - 1);
      rec.done = rec.last && f;
      expected_bytes.push_back(rec);
    end
  endfunction

  always @(posedge clk) begin
    out_rec_t want;
    if (rst) begin
      start_digits(PH_IDLE);
      hi_unit = '0;
      for (int k = 0; k < HELD_DEPTH; k++) held[k] = '0;
      expected_bytes.delete();
    end else begin
      if (in_valid && in_ready) begin
        decode_request(in_byte, is_final);
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          err_n++;
          $display("%0t: unexpected output byte, expected none actual %02h", $time,
                   out_byte);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data) begin
            err_n++;
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
          end
          if (run_end !== want.last) begin
            err_n++;
            $display("%0t: run_end expected %0b actual %0b", $time, want.last, run_end);
          end
          if (string_done !== want.done) begin
            err_n++;
            $display("%0t: string_done expected %0b actual %0b", $time, want.done,
                     string_done);
          end
        end
      end
    end
    pending <= expected_bytes.size();
    errors <= err_n;
  end

endmodule

[sim/json_string_unescape_utf8_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top_tb
// Testbench of the JSON string unescaper.
// ----------------------------------------------------------------------------
// Feeds string bodies byte by byte: a directed set covering byte extremes,
// every escape, backslash and \u at string end, bad hex digits, short \u,
// lone and paired surrogates, then random strings built mostly from escape
// tokens, some cut short. Both sides stall at random, with one stretch at
// full rate. The checker beside the block predicts and compares; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top_tb;
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam int RANDOM_ITEMS = 112;
  localparam int DRAIN_CYCLES = 64;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       is_final = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_done;
  int         errors;
  int         pending;

  logic       idle_on = 1'b1;
  int         bytes_sent = 0;
  logic [7:0] str_q [$];
  logic [7:0] esc_chars [8] = '{CH_N, CH_R, CH_T, CH_B, CH_F, CH_QUOTE, CH_BSLASH, CH_SLASH};
  string      hex_lower = "0123456789abcdef";
  string      hex_upper = "0123456789ABCDEF";
  string      non_hex = "gGxXzZ!:-u\\";

  json_string_unescape_utf8_top dut (.*);

  json_string_unescape_utf8_check u_check (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= !idle_on || ($urandom_range(99) >= 34);
  end

  task automatic send_byte(input logic [7:0] b, input logic f);
    if (idle_on && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 34);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    is_final <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_queue();
    int i;
    for (i = 0; i < str_q.size(); i++) send_byte(str_q[i], i == str_q.size() - 1);
    str_q.delete();
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) str_q.push_back(s[i]);
    send_queue();
  endtask

  function automatic logic [15:0] random_unit();
    case ($urandom_range(4))
      0: return 16'($urandom_range(16'h7F));
      1: return 16'($urandom_range(16'h7FF));
      2: return 16'($urandom);
      3: return HI_FIRST + 16'($urandom_range(1023));
      default: return LO_FIRST + 16'($urandom_range(1023));
    endcase
  endfunction

  task automatic push_esc_u(input logic [15:0] u, input bit spoil);
    int i;
    int n;
    int bad_pos;
    bad_pos = spoil ? $urandom_range(3) : -1;
    str_q.push_back(CH_BSLASH);
    str_q.push_back(CH_U);
    for (i = 3; i >= 0; i--) begin
      n = u[4*i +: 4];
      if (i == bad_pos) begin
        if ($urandom_range(1)) begin
          str_q.push_back(8'($urandom_range(255, 128)));
        end else begin
          str_q.push_back(non_hex[$urandom_range(non_hex.len() - 1)]);
        end
      end else if ($urandom_range(1)) begin
        str_q.push_back(hex_upper[n]);
      end else begin
        str_q.push_back(hex_lower[n]);
      end
    end
  endtask

  task automatic add_token();
    logic [7:0] b;
    case ($urandom_range(7))
      0, 1: str_q.push_back(8'($urandom_range(255)));
      2: begin
        str_q.push_back(CH_BSLASH);
        str_q.push_back(esc_chars[$urandom_range(7)]);
      end
      3: begin
        str_q.push_back(CH_BSLASH);
        str_q.push_back(8'($urandom_range(255)));
      end
      4: push_esc_u(random_unit(), $urandom_range(99) < 20);
      5: begin
        push_esc_u(HI_FIRST + 16'($urandom_range(1023)), 1'b0);
        push_esc_u(LO_FIRST + 16'($urandom_range(1023)), 1'b0);
      end
      6: begin
        // high surrogate followed by a raw byte, another escape, a random \u or a spoiled low surrogate
        push_esc_u(HI_FIRST + 16'($urandom_range(1023)), 1'b0);
        case ($urandom_range(3))
          0: str_q.push_back(8'($urandom_range(255)));
          1: begin
            b = 8'($urandom_range(255));
            if (b == CH_U) begin
              b = CH_N;
            end
            str_q.push_back(CH_BSLASH);
            str_q.push_back(b);
          end
          2: push_esc_u(random_unit(), 1'b0);
          default: push_esc_u(LO_FIRST + 16'($urandom_range(1023)), 1'b1);
        endcase
      end
      default: push_esc_u(random_unit(), 1'b1);
    endcase
  endtask

  initial begin
    int start;
    int ntok;
    int keep;
    int i;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    str_q.push_back(8'h00);
    str_q.push_back(8'hFF);
    send_queue();
    send_text("\\n\\r\\t\\b\\f\\\"\\\\\\/\\q");
    send_text("\\");
    send_text("\\u");
    send_text("\\u12G4");
    send_text("\\u4a");
    send_text("\\uDBFFz");
    send_text("\\uD83D\\uDE00");
    send_text("\\uDC00");

    start = bytes_sent;
    while (bytes_sent < start + RANDOM_ITEMS) begin
      // full rate for a stretch in the middle
      idle_on <= (bytes_sent - start) < 40 || (bytes_sent - start) >= 80;
      ntok = $urandom_range(5, 1);
      for (i = 0; i < ntok; i++) add_token();
      if ($urandom_range(99) < 25) begin
        keep = $urandom_range(str_q.size(), 1);
        while (str_q.size() > keep) void'(str_q.pop_back());
      end
      send_queue();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
